/* design/drs_pkg.sv */
// Package for the delimited region scanner.
// Holds the configuration and result types and the register map; no dependencies.
package drs_pkg;

  localparam logic [7:0] BACKSLASH = 8'h5C;

  localparam logic [15:0] BEGIN_CHARS_RST = 16'h2A2F;
  localparam logic [1:0]  BEGIN_LEN_RST   = 2'd2;
  localparam logic [15:0] END_CHARS_RST   = 16'h2F2A;
  localparam logic [1:0]  END_LEN_RST     = 2'd2;
  localparam logic        ESCAPE_EN_RST   = 1'b0;

  localparam int CFG_ADDR_BITS = 5;

  typedef enum logic [2:0] {
    REG_BEGIN_CHARS = 3'd0,
    REG_BEGIN_LEN   = 3'd1,
    REG_END_CHARS   = 3'd2,
    REG_END_LEN     = 3'd3,
    REG_ESCAPE_EN   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] begin_chars;
    logic        begin_two;
    logic [15:0] end_chars;
    logic        end_two;
    logic        escape_en;
  } scan_cfg_t;

  typedef struct packed {
    logic [15:0] length;
    logic        found;
  } scan_res_t;

endpackage

/* design/drs_cfg.sv */
// Configuration register file with an APB-style write and read port.
// Depends on drs_pkg for the register map and the configuration struct.
module drs_cfg import drs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output scan_cfg_t                cfg
);

  logic [15:0] begin_chars_r;
  logic [1:0]  begin_len_r;
  logic [15:0] end_chars_r;
  logic [1:0]  end_len_r;
  logic        escape_en_r;
  logic        wr_en;
  reg_idx_t    idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      begin_chars_r <= BEGIN_CHARS_RST;
      begin_len_r   <= BEGIN_LEN_RST;
      end_chars_r   <= END_CHARS_RST;
      end_len_r     <= END_LEN_RST;
      escape_en_r   <= ESCAPE_EN_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_BEGIN_CHARS: begin_chars_r <= pwdata[15:0];
        REG_BEGIN_LEN:   begin_len_r   <= pwdata[1:0];
        REG_END_CHARS:   end_chars_r   <= pwdata[15:0];
        REG_END_LEN:     end_len_r     <= pwdata[1:0];
        REG_ESCAPE_EN:   escape_en_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BEGIN_CHARS: prdata = {16'd0, begin_chars_r};
      REG_BEGIN_LEN:   prdata = {30'd0, begin_len_r};
      REG_END_CHARS:   prdata = {16'd0, end_chars_r};
      REG_END_LEN:     prdata = {30'd0, end_len_r};
      REG_ESCAPE_EN:   prdata = {31'd0, escape_en_r};
      default:         prdata = 32'd0;
    endcase
  end

  // A length of zero acts as one and a length of three acts as two.
  always_comb begin
    cfg.begin_chars = begin_chars_r;
    cfg.begin_two   = begin_len_r[1];
    cfg.end_chars   = end_chars_r;
    cfg.end_two     = end_len_r[1];
    cfg.escape_en   = escape_en_r;
  end

endmodule

/* design/drs_core.sv */
// Per-character scan logic: scan state registers and the single-pass match decision.
// Depends on drs_pkg for the configuration and result structs.
module drs_core import drs_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  logic [7:0] ch,
  input  logic      first,
  input  scan_cfg_t cfg,
  output logic      res_valid,
  output scan_res_t res
);

  localparam int CW = (COUNT_BITS < 16) ? COUNT_BITS : 16;

  logic          active_r, active_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [15:0]   recent_r, recent_nxt;

  logic          act;
  logic [CW-1:0] q;
  logic [15:0]   rec;
  logic [CW-1:0] q_inc;
  logic          at_limit;
  logic          in_begin;
  logic [7:0]    want;
  logic          hit;
  logic [7:0]    prev;
  logic          done;
  logic          ok;

  always_comb begin
    act   = first || active_r;
    q     = first ? '0 : count_r;
    rec   = first ? 16'd0 : recent_r;
    q_inc = q + CW'(1);
    at_limit = &q;
    in_begin = (q == '0) || (cfg.begin_two && (q == CW'(1)));
    want     = (q == '0) ? cfg.begin_chars[7:0] : cfg.begin_chars[15:8];
    if (!cfg.end_two) begin
      hit  = (ch == cfg.end_chars[7:0]);
      prev = rec[7:0];
    end else begin
      hit  = (q > CW'({1'b0, cfg.begin_two} + 2'd1)) &&
             (rec[7:0] == cfg.end_chars[7:0]) && (ch == cfg.end_chars[15:8]);
      prev = rec[15:8];
    end
    ok = 1'b0;
    if (at_limit || (ch == 8'd0)) begin
      done = 1'b1;
    end else if (in_begin) begin
      done = (ch != want);
    end else begin
      ok   = hit && !(cfg.escape_en && (prev == BACKSLASH));
      done = ok;
    end

    res_valid  = accept && act && done;
    res.found  = ok;
    res.length = ok ? 16'(q_inc) : 16'd0;

    active_nxt = active_r;
    count_nxt  = count_r;
    recent_nxt = recent_r;
    if (accept && act) begin
      active_nxt = !done;
      count_nxt  = q_inc;
      recent_nxt = {rec[7:0], ch};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      count_r  <= '0;
      recent_r <= 16'd0;
    end else begin
      active_r <= active_nxt;
      count_r  <= count_nxt;
      recent_r <= recent_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !first && !active_r) |-> !res_valid) else $error("result without scan");
  a_end_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> !active_r) else $error("scan still active after result");
  a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.found) |-> (res.length != 16'd0)) else $error("match with zero length");
`endif

endmodule

/* design/drs_outbuf.sv */
// Two-entry output buffer: result register plus skid register.
// Depends on drs_pkg for the result struct.
module drs_outbuf import drs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  scan_res_t push_res,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output scan_res_t out_res
);

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  scan_res_t out_res_r, out_res_nxt;
  scan_res_t skid_res_r, skid_res_nxt;
  logic      free;

  assign room      = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    free           = !out_valid_r || out_ready;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = push;
        skid_res_nxt   = push_res;
      end else begin
        out_valid_nxt = push;
        out_res_nxt   = push_res;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r) else $error("skid word ahead of output word");
  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_ready) |=> skid_valid_r) else $error("skid word lost");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !push) else $error("push into full buffer");
`endif

endmodule

/* design/delimited_region_scanner.sv */
// Delimited region scanner, top level. A result word is registered into the
// output register when the character that completes the scan is accepted, or
// goes to the skid register if an earlier word still waits there.
// Throughput: one character per cycle; the input stalls only while both the
// output register and the skid register hold words not yet taken.
// Reset (rst_n, synchronous, active low) drops any scan, empties the output
// buffer and returns the configuration registers to their default values.
module delimited_region_scanner import drs_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_tdata,   // [7:0] ch
  input  logic [0:0]               in_tuser,   // [0] first
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [15:0]              out_tdata,  // [15:0] length
  output logic [0:0]               out_tuser,  // [0] found
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [31:0]              cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);

  scan_cfg_t cfg;
  scan_res_t res;
  scan_res_t out_res;
  logic      res_valid;
  logic      room;
  logic      accept;

  assign cfg_pready = 1'b1;
  assign in_tready  = room;
  assign accept     = in_tvalid && room;
  assign out_tdata  = out_res.length;
  assign out_tuser  = out_res.found;

  drs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  drs_core #(.COUNT_BITS(COUNT_BITS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .ch        (in_tdata),
    .first     (in_tuser[0]),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  drs_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_res  (res),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

endmodule

/* bench/tb_delimited_region_scanner.sv */
// Testbench for delimited_region_scanner: streams characters in, checks each result word.
// A scoreboard class predicts every result from its own copy of the scan state and registers.
// Depends on drs_pkg and the scanner RTL only.
module tb_delimited_region_scanner;
  import drs_pkg::*;

  localparam int COUNT_BITS = 16;
  localparam int MAX_REGION = (COUNT_BITS >= 16) ? 65535 : (1 << COUNT_BITS) - 1;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int RANDOM_PHASES = 8;
  localparam int CHARS_PER_PHASE = 180;

  class region_scoreboard;
    logic [15:0] begin_chars;
    logic [1:0]  begin_len;
    logic [15:0] end_chars;
    logic [1:0]  end_len;
    logic        escape_en;
    bit          scan_active;
    int          char_count;
    logic [23:0] recent;
    scan_res_t   regions_due[$];
    int          errors;
    int          live_chars;

    function new();
      begin_chars = BEGIN_CHARS_RST;
      begin_len   = BEGIN_LEN_RST;
      end_chars   = END_CHARS_RST;
      end_len     = END_LEN_RST;
      escape_en   = ESCAPE_EN_RST;
      scan_active = 0;
      char_count  = 0;
      recent      = '0;
      errors      = 0;
      live_chars  = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_BEGIN_CHARS: begin_chars = value[15:0];
        REG_BEGIN_LEN:   begin_len   = value[1:0];
        REG_END_CHARS:   end_chars   = value[15:0];
        REG_END_LEN:     end_len     = value[1:0];
        REG_ESCAPE_EN:   escape_en   = value[0];
        default: ;
      endcase
    endfunction

    // A delimiter length of zero acts as one and three acts as two.
    function int span(logic [1:0] n);
      if (n == 2'd0) return 1;
      if (n == 2'd3) return 2;
      return int'(n);
    endfunction

    function void close_scan(logic found, logic [15:0] len);
      scan_res_t r;
      r.found  = found;
      r.length = len;
      regions_due.push_back(r);
      scan_active = 0;
    endfunction

    function void note_char(logic [7:0] ch, bit first);
      int q, blen, elen;
      bit hit;
      logic [7:0] prior;
      if (first) begin
        scan_active = 1;
        char_count  = 0;
        recent      = '0;
      end
      if (!scan_active) return;
      live_chars++;
      q = char_count;
      blen = span(begin_len);
      elen = span(end_len);
      hit = 0;
      prior = 8'h00;
      if (q >= MAX_REGION || ch == 8'h00) begin
        close_scan(1'b0, 16'h0000);
        return;
      end
      if (q < blen) begin
        if (ch != begin_chars[8*q +: 8]) begin
          close_scan(1'b0, 16'h0000);
          return;
        end
      end else if (elen == 1) begin
        hit = (ch == end_chars[7:0]);
        prior = recent[7:0];
      end else if (q >= blen + 1) begin
        hit = (recent[7:0] == end_chars[7:0]) && (ch == end_chars[15:8]);
        prior = recent[15:8];
      end
      if (hit && !(escape_en && prior == BACKSLASH)) begin
        close_scan(1'b1, 16'(q + 1));
        return;
      end
      char_count = (q + 1) & 16'hFFFF;
      recent = {recent[15:0], ch};
    endfunction

    function void report(string what, logic [15:0] want_v, logic [15:0] got_v);
      errors++;
      if (errors <= 10)
        $display("mismatch %0d: %s expected %0d got %0d", errors, what, want_v, got_v);
    endfunction

    function void check_word(logic found, logic [15:0] len);
      scan_res_t want;
      if (regions_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch %0d: word found=%0d length=%0d arrived with none expected",
                   errors, found, len);
        return;
      end
      want = regions_due.pop_front();
      if (found !== want.found) report("found", 16'(want.found), 16'(found));
      if (len !== want.length) report("length", want.length, len);
    endfunction

    function int pending();
      return regions_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] ch
  logic [0:0]  in_tuser;   // [0] first
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [15:0] length
  logic [0:0]  out_tuser;  // [0] found
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  region_scoreboard sb;
  int burst_left;
  int rx_tick;
  int cycles;

  delimited_region_scanner #(.COUNT_BITS(COUNT_BITS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tuser[0], out_tdata);
  end

  // The receiver cycles through always ready, coin flips, a fixed duty pattern and heavy stalls.
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    case ((rx_tick / 256) % 4)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 1);
      2: out_tready <= ((rx_tick % 7) < 3);
      default: out_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  task automatic idle_input(input int n);
    in_tvalid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_word(input logic [7:0] ch, input bit first);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 6));
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tuser  <= first;
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    sb.note_char(ch, first);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], i == 0);
  endtask

  task automatic wait_for_regions();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(input reg_idx_t idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_pready) break;
    end
    sb.set_reg(idx, value);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_all(input logic [15:0] bchars, input logic [1:0] blen,
                           input logic [15:0] echars, input logic [1:0] elen, input logic esc);
    write_cfg(REG_BEGIN_CHARS, {16'($urandom_range(0, 65535)), bchars});
    write_cfg(REG_BEGIN_LEN, {16'($urandom_range(0, 65535)), 14'h0000, blen});
    write_cfg(REG_END_CHARS, {16'($urandom_range(0, 65535)), echars});
    write_cfg(REG_END_LEN, {16'($urandom_range(0, 65535)), 14'h0000, elen});
    write_cfg(REG_ESCAPE_EN, {16'($urandom_range(0, 65535)), 15'h0000, esc});
  endtask

  function automatic logic [7:0] pick_delim();
    case ($urandom_range(0, 9))
      0: return "/";
      1: return "*";
      2: return "\"";
      3: return "'";
      4: return "#";
      5: return BACKSLASH;
      6: return 8'hFF;
      7: return "<";
      8: return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'h01;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic logic [7:0] body_char();
    case ($urandom_range(0, 15))
      0, 1, 2: return sb.end_chars[7:0];
      3, 4: return sb.end_chars[15:8];
      5, 6: return BACKSLASH;
      7: return sb.begin_chars[7:0];
      8: return ($urandom_range(0, 3) == 0) ? 8'h00 : " ";
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic random_scan();
    int kind, body;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6))
        send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end else if (kind == 1) begin
      send_word(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      send_word(sb.begin_chars[7:0], 1'b1);
      if (sb.span(sb.begin_len) == 2)
        send_word(($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                               : sb.begin_chars[15:8], 1'b0);
      body = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
      repeat (body) send_word(body_char(), 1'b0);
      if ($urandom_range(0, 9) < 7) begin
        if (sb.escape_en && $urandom_range(0, 2) == 0) send_word(BACKSLASH, 1'b0);
        send_word(sb.end_chars[7:0], 1'b0);
        if (sb.span(sb.end_len) == 2) send_word(sb.end_chars[15:8], 1'b0);
      end
      if ($urandom_range(0, 3) == 0) send_word(body_char(), 1'b0);
    end
  endtask

  initial begin
    int target;
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b1;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    burst_left = 0;
    rx_tick = 0;
    cycles = 0;
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_word("q", 1'b0);
    send_text("/**/");
    send_text("/*/*/");
    send_text("x");
    send_word("/", 1'b1);
    send_word(8'h00, 1'b0);
    send_text("/*a");
    send_word(8'h00, 1'b0);
    send_text("/*a");
    send_text("/*\\*/");
    send_text("/*");
    send_word(8'hFF, 1'b0);
    send_text("*/");
    wait_for_regions();

    write_all(16'h0022, 2'd1, 16'h0022, 2'd1, 1'b1);
    send_text("\"ab\\\"c\"");
    send_text("\"\"");
    send_text("\"x");
    send_word(8'h00, 1'b0);
    wait_for_regions();

    write_all(16'h2A2F, 2'd0, 16'h2F2A, 2'd3, 1'b1);
    send_text("/*/");
    send_text("//*/");
    send_text("/\\*/*/");
    wait_for_regions();

    write_all(16'h0000, 2'd2, 16'hFFFF, 2'd2, 1'b1);
    send_word(8'h00, 1'b1);
    send_word("a", 1'b1);
    wait_for_regions();
    write_cfg(REG_BEGIN_CHARS, 32'h0000FFFF);
    write_cfg(REG_BEGIN_LEN, 32'h00000003);
    repeat (4) send_word(8'hFF, 1'b0 == 1'b1);
    send_word(8'hFF, 1'b1);
    repeat (3) send_word(8'hFF, 1'b0);
    wait_for_regions();
    write_cfg(REG_END_CHARS, 32'h00000000);
    write_cfg(REG_END_LEN, 32'h00000000);
    send_word(8'hFF, 1'b1);
    send_word(8'hFF, 1'b0);
    send_word("a", 1'b0);
    send_word(8'h00, 1'b0);
    wait_for_regions();

    target = sb.live_chars;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_all({pick_delim(), pick_delim()}, 2'($urandom_range(0, 3)),
                {pick_delim(), pick_delim()}, 2'($urandom_range(0, 3)),
                1'($urandom_range(0, 1)));
      target += CHARS_PER_PHASE;
      while (sb.live_chars < target) random_scan();
      wait_for_regions();
    end
    repeat (8) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/drs_pkg.sv
design/drs_cfg.sv
design/drs_core.sv
design/drs_outbuf.sv
design/delimited_region_scanner.sv
bench/tb_delimited_region_scanner.sv
